// ===== rtl/tvi_pkg.sv =====
`default_nettype none

package tvi_pkg;

    // Field widths of the stream items
    localparam int POS_W       = 25;
    localparam int VOX_W       = 16;
    localparam int NUM_VOX     = 8;
    localparam int SIZE_W      = 16;

    // Packed stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_VOLUME_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_VOLUME_HEIGHT = 2'd1;
    localparam cfg_idx_t REG_VOLUME_DEPTH  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/trilinear_voxel_interpolator_unit.sv =====
// Trilinear voxel interpolator.
// Input stream (s_axis_*): one transfer carries a fixed-point sample position
// and the eight voxels of the cell around it. Output stream (m_axis_*): one
// transfer per input carries the interpolated intensity (tdata) and an
// out-of-range flag (tuser); intensity is zero when the flag is set.
// The cfg_* channel writes the volume width, height and depth (indexes 0, 1,
// 2); it is always ready and should be used only while the pipeline is empty.
// Throughput: one item per cycle while the receiver is ready. Each input
// transfer reaches output valid through four register stages: one per lerp
// level (x, y, z) plus the rounding and output register stage. The x
// level holds four sample-by-fraction multipliers, the y level two and
// the z level one. Reset clears all stage valid bits and sets each volume
// size to 1, so every sample reads out of range until the sizes are written.
// When the receiver stalls, each full stage holds its item while an empty
// stage keeps loading, so bubbles close up and no item is dropped or
// repeated; s_axis_tready falls once all four stages hold items.
`default_nettype none

module trilinear_voxel_interpolator_unit #(
    parameter int FRAC_BITS   = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // config write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tvi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tvi_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // from bit 0: pos_x[25], pos_y[25], pos_z[25], voxel_000, voxel_100,
    // voxel_010, voxel_110, voxel_001, voxel_101, voxel_011, voxel_111 [16 each],
    // zero pad[5]
    input  wire logic [tvi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // from bit 0: intensity[16]
    output logic [tvi_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // from bit 0: out_of_range[1]
    output logic                                    m_axis_tuser
);
    import tvi_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int SB     = SAMPLE_BITS;
    localparam int L1_W   = SB + F;
    localparam int L2_W   = SB + 2 * F;
    localparam int L3_W   = SB + 3 * F;
    localparam int BASE_W = POS_W - 1 - F;
    localparam logic [L3_W-1:0] HALF = {{(L3_W-1){1'b0}}, 1'b1} << (3 * F - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] vol_width_reg,  vol_width_next;
    logic [SIZE_W-1:0] vol_height_reg, vol_height_next;
    logic [SIZE_W-1:0] vol_depth_reg,  vol_depth_next;

    assign cfg_ready = 1'b1;

    // Decode the register write; unused indexes are dropped
    always_comb
    begin
        vol_width_next  = vol_width_reg;
        vol_height_next = vol_height_reg;
        vol_depth_next  = vol_depth_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VOLUME_WIDTH:  vol_width_next  = cfg_data;
                REG_VOLUME_HEIGHT: vol_height_next = cfg_data;
                REG_VOLUME_DEPTH:  vol_depth_next  = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_width_reg  <= SIZE_W'(1);
            vol_height_reg <= SIZE_W'(1);
            vol_depth_reg  <= SIZE_W'(1);
        end
        else
        begin
            vol_width_reg  <= vol_width_next;
            vol_height_reg <= vol_height_next;
            vol_depth_reg  <= vol_depth_next;
        end
    end

    // ---------------------------------------------------------------
    // Input unpack and range check
    // ---------------------------------------------------------------
    logic [POS_W-1:0]  pos   [3];
    logic [SIZE_W-1:0] vsize [3];
    logic [F-1:0]      frac  [3];
    logic [2:0]        axis_bad;
    logic [SB-1:0]     vox   [NUM_VOX];
    logic              oor_in;

    assign vsize[0] = vol_width_reg;
    assign vsize[1] = vol_height_reg;
    assign vsize[2] = vol_depth_reg;

    // Split each coordinate; flag a negative value or a far corner past the edge
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pos[a]  = s_axis_tdata[a*POS_W +: POS_W];
            frac[a] = pos[a][F-1:0];
            axis_bad[a] = pos[a][POS_W-1] ||
                (POS_W'(pos[a][POS_W-2:F]) + POS_W'(1) >= POS_W'(vsize[a]));
        end
        for (int v = 0; v < NUM_VOX; v++)
        begin
            vox[v] = s_axis_tdata[3*POS_W + v*VOX_W +: SB];
        end
    end

    assign oor_in = |axis_bad;

    // ---------------------------------------------------------------
    // Pipeline handshake: a stage loads when empty or when its successor loads
    // ---------------------------------------------------------------
    logic valid1_reg, valid1_next;
    logic valid2_reg, valid2_next;
    logic valid3_reg, valid3_next;
    logic valid4_reg, valid4_next;
    logic ready1, ready2, ready3, ready4;

    assign ready4 = !valid4_reg || m_axis_tready;
    assign ready3 = !valid3_reg || ready4;
    assign ready2 = !valid2_reg || ready3;
    assign ready1 = !valid1_reg || ready2;

    assign s_axis_tready = ready1;

    assign valid1_next = ready1 ? s_axis_tvalid : valid1_reg;
    assign valid2_next = ready2 ? valid1_reg    : valid2_reg;
    assign valid3_next = ready3 ? valid2_reg    : valid3_reg;
    assign valid4_next = ready4 ? valid3_reg    : valid4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
            valid3_reg <= valid3_next;
            valid4_reg <= valid4_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: lerp along x. lerp = lo*2^F + (hi - lo)*f, exact modulo the
    // result width since the true value always fits
    // ---------------------------------------------------------------
    logic [L1_W-1:0] c1_reg [4];
    logic [L1_W-1:0] c1_next [4];
    logic [F-1:0]    fy1_reg, fy1_next;
    logic [F-1:0]    fz1_reg, fz1_next;
    logic            oor1_reg, oor1_next;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            c1_next[j] = (L1_W'(vox[2*j]) << F)
                       + (L1_W'(vox[2*j+1]) - L1_W'(vox[2*j])) * L1_W'(frac[0]);
        end
        fy1_next  = frac[1];
        fz1_next  = frac[2];
        oor1_next = oor_in;
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            for (int j = 0; j < 4; j++)
            begin
                c1_reg[j] <= c1_next[j];
            end
            fy1_reg  <= fy1_next;
            fz1_reg  <= fz1_next;
            oor1_reg <= oor1_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: lerp along y
    // ---------------------------------------------------------------
    logic [L2_W-1:0] c2_reg [2];
    logic [L2_W-1:0] c2_next [2];
    logic [F-1:0]    fz2_reg, fz2_next;
    logic            oor2_reg, oor2_next;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            c2_next[j] = (L2_W'(c1_reg[2*j]) << F)
                       + (L2_W'(c1_reg[2*j+1]) - L2_W'(c1_reg[2*j])) * L2_W'(fy1_reg);
        end
        fz2_next  = fz1_reg;
        oor2_next = oor1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            for (int j = 0; j < 2; j++)
            begin
                c2_reg[j] <= c2_next[j];
            end
            fz2_reg  <= fz2_next;
            oor2_reg <= oor2_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: lerp along z
    // ---------------------------------------------------------------
    logic [L3_W-1:0] c3_reg, c3_next;
    logic            oor3_reg, oor3_next;

    assign c3_next = (L3_W'(c2_reg[0]) << F)
                   + (L3_W'(c2_reg[1]) - L3_W'(c2_reg[0])) * L3_W'(fz2_reg);
    assign oor3_next = oor2_reg;

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            c3_reg   <= c3_next;
            oor3_reg <= oor3_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: round half up, zero out-of-range results, hold for the receiver
    // ---------------------------------------------------------------
    logic [L3_W-1:0]        rounded;
    logic [OUT_TDATA_W-1:0] intensity_reg, intensity_next;
    logic                   oor4_reg, oor4_next;

    assign rounded        = c3_reg + HALF;
    assign intensity_next = oor3_reg ? '0 : OUT_TDATA_W'(rounded[L3_W-1:3*F]);
    assign oor4_next      = oor3_reg;

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            intensity_reg <= intensity_next;
            oor4_reg      <= oor4_next;
        end
    end

    assign m_axis_tvalid = valid4_reg;
    assign m_axis_tdata  = intensity_reg;
    assign m_axis_tuser  = oor4_reg;

    // BASE_W documents the integer part width used in the range compare
    if (BASE_W < 1)
    begin : g_bad_frac
        $error("FRAC_BITS leaves no integer bits");
    end

endmodule

`default_nettype wire
